@@ design/ssd_pkg.sv @@
// Shared constants, command and status codes, and control types for the stack block.
`default_nettype none
package ssd_pkg;

    // Field widths that the interface fixes.
    localparam int VAL_W    = 31;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;
    localparam int DEPTH_DEF = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SORT = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO     = 2'd3;

    // Control from the sequencer to the sorting array.
    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } t_sort_ctl;

endpackage
`default_nettype wire

@@ design/ssd_mem.sv @@
// Stack storage: one write port and one read port with registered read data.
`default_nettype none
module ssd_mem
    import ssd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [VAL_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ design/ssd_sort.sv @@
// Insertion sorting array that keeps its contents in descending order and shifts out.
`default_nettype none
module ssd_sort
    import ssd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire t_sort_ctl        i_ctl,
    input  wire logic [VAL_W-1:0] i_data,
    output logic      [VAL_W-1:0] o_top
);

    logic [VAL_W-1:0] r_s [DEPTH];
    logic [VAL_W-1:0] n_s [DEPTH];
    logic [DEPTH-1:0] gt;

    // Each cell compares the new value with its own entry; the result is monotone.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            gt[k] = i_data > r_s[k];
        end
        for (int k = 0; k < DEPTH; k++) begin
            if (!gt[k]) begin
                n_s[k] = r_s[k];
            end else if (k == 0) begin
                n_s[k] = i_data;
            end else if (gt[(k + DEPTH - 1) % DEPTH]) begin
                n_s[k] = r_s[(k + DEPTH - 1) % DEPTH];
            end else begin
                n_s[k] = i_data;
            end
        end
    end

    // Clear, insert or shift the array toward the top cell.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_ctl.clear) begin
                r_s[k] <= '0;
            end else if (i_ctl.insert) begin
                r_s[k] <= n_s[k];
            end else if (i_ctl.shift) begin
                r_s[k] <= (k == DEPTH - 1) ? '0 : r_s[(k + 1) % DEPTH];
            end
        end
    end

    assign o_top = r_s[0];

endmodule
`default_nettype wire

@@ design/shift_stack_with_sorted_dump.sv @@
// Bounded stack with peek, multi-entry pop, dump and sorted dump commands.
//
// A command request enters on the s group: tuser holds the command, tdata the
// operand (value to push or count to pop). Results leave on the m group, one
// request each: tuser holds the status, tdata value, position and occupancy,
// and tlast marks the final result of a command.
// One command is worked on at a time. Push and the single-result pop cases
// (count zero or too large) load their result into the output register from
// the decode state once the output register is free. Peek, pop and dump pass
// the decode state and then, per result, an issue state for the memory read
// and a data state to load the output register; a dump gives DEPTH results.
// A sorted dump clears the insertion array in the decode state, reads the
// occupied entries into it at one per cycle and then shifts out DEPTH results
// at one per cycle while the receiver takes them.
// The output register holds a result until it is taken; the next command may
// be accepted while the final result of the previous one still waits. When
// the receiver stalls the sequencer waits with the result pending.
// Reset empties the stack at once; no clearing pass runs, since entries above
// the occupancy are never read.
`default_nettype none
module shift_stack_with_sorted_dump
    import ssd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int AW    = $clog2(DEPTH),
    parameter int IN_W  = ((VAL_W + 7) / 8) * 8,
    parameter int OUT_W = ((VAL_W + 2 * CW + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [IN_W-1:0]   i_s_tdata,   // operand
    input  wire logic [CMD_W-1:0]  i_s_tuser,   // cmd
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [OUT_W-1:0]  o_m_tdata,   // value, position, occupancy
    output logic      [STAT_W-1:0] o_m_tuser,   // status
    output logic                   o_m_tlast    // last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ISSUE,
        S_DATA,
        S_SLOAD,
        S_SEMIT
    } t_state;

    t_state            r_state;
    logic [CMD_W-1:0]  r_cmd;
    logic [VAL_W-1:0]  r_opnd;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_total;
    logic              r_hit;
    logic              r_ins;

    logic              r_out_vld;
    logic [STAT_W-1:0] r_status;
    logic [VAL_W-1:0]  r_value;
    logic [CW-1:0]     r_pos;
    logic [CW-1:0]     r_occ;
    logic              r_last;

    logic              out_free;
    logic              out_load;
    logic              hit;
    logic [CW-1:0]     rd_off;
    logic              pop_big;
    logic              push_ok;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [VAL_W-1:0]  mem_rdata;
    logic [VAL_W-1:0]  sort_top;
    t_sort_ctl         sort_ctl;

    // Common conditions.
    assign out_free = !r_out_vld || i_m_tready;
    assign hit      = r_idx < r_cnt;
    assign rd_off   = r_cnt - r_idx - CW'(1);
    assign pop_big  = r_opnd > {{(VAL_W - CW){1'b0}}, r_cnt};
    assign push_ok  = (r_opnd != '0) && (r_cnt < CW'(DEPTH));

    // The sequencer loads a new result into the output register this cycle.
    always_comb begin
        case (r_state)
            S_DECODE: begin
                out_load = out_free && ((r_cmd == CMD_PUSH) ||
                           ((r_cmd == CMD_POP) && (pop_big || (r_opnd == '0))));
            end
            S_DATA: begin
                out_load = out_free;
            end
            S_SEMIT: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Memory and sorter control from the sequencer state.
    always_comb begin
        mem_we          = (r_state == S_DECODE) && (r_cmd == CMD_PUSH) && push_ok && out_free;
        mem_re          = ((r_state == S_ISSUE) || (r_state == S_SLOAD)) && hit;
        mem_raddr       = (r_state == S_SLOAD) ? r_idx[AW-1:0] : rd_off[AW-1:0];
        sort_ctl.clear  = (r_state == S_DECODE) && (r_cmd == CMD_SORT);
        sort_ctl.insert = (r_state == S_SLOAD) && r_ins;
        sort_ctl.shift  = (r_state == S_SEMIT) && out_free;
    end

    ssd_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_opnd),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ssd_sort #(
        .DEPTH (DEPTH)
    ) u_sort (
        .i_clk  (i_clk),
        .i_ctl  (sort_ctl),
        .i_data (mem_rdata),
        .o_top  (sort_top)
    );

    // Sequencer, stack count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
            r_ins     <= 1'b0;
        end else begin
            if (i_m_tready && !out_load) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cmd   <= i_s_tuser;
                        r_opnd  <= i_s_tdata[VAL_W-1:0];
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_idx <= '0;
                    case (r_cmd)
                        CMD_PUSH: begin
                            if (out_free) begin
                                r_out_vld <= 1'b1;
                                r_last    <= 1'b1;
                                if (r_opnd == '0) begin
                                    r_status <= ST_ZERO;
                                    r_value  <= '0;
                                    r_pos    <= r_cnt;
                                    r_occ    <= r_cnt;
                                end else if (!push_ok) begin
                                    r_status <= ST_FULL;
                                    r_value  <= '0;
                                    r_pos    <= r_cnt;
                                    r_occ    <= r_cnt;
                                end else begin
                                    r_status <= ST_OK;
                                    r_value  <= r_opnd;
                                    r_pos    <= r_cnt + CW'(1);
                                    r_occ    <= r_cnt + CW'(1);
                                    r_cnt    <= r_cnt + CW'(1);
                                end
                                r_state <= S_IDLE;
                            end
                        end
                        CMD_PEEK: begin
                            r_total <= CW'(1);
                            r_state <= S_ISSUE;
                        end
                        CMD_POP: begin
                            if (pop_big || (r_opnd == '0)) begin
                                if (out_free) begin
                                    r_out_vld <= 1'b1;
                                    r_last    <= 1'b1;
                                    r_status  <= pop_big ? ST_TOO_MANY : ST_OK;
                                    r_value   <= '0;
                                    r_pos     <= r_cnt;
                                    r_occ     <= r_cnt;
                                    r_state   <= S_IDLE;
                                end
                            end else begin
                                r_total <= r_opnd[CW-1:0];
                                r_state <= S_ISSUE;
                            end
                        end
                        CMD_DUMP: begin
                            r_total <= CW'(DEPTH);
                            r_state <= S_ISSUE;
                        end
                        CMD_SORT: begin
                            r_ins   <= 1'b0;
                            r_state <= S_SLOAD;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_ISSUE: begin
                    r_hit   <= hit;
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_status  <= ST_OK;
                        r_value   <= r_hit ? mem_rdata : '0;
                        r_last    <= (r_idx == r_total - CW'(1));
                        case (r_cmd)
                            CMD_POP: begin
                                r_pos <= r_cnt - r_idx;
                                r_occ <= r_cnt - r_total;
                            end
                            CMD_DUMP: begin
                                r_pos <= r_idx;
                                r_occ <= r_cnt;
                            end
                            default: begin
                                r_pos <= r_cnt;
                                r_occ <= r_cnt;
                            end
                        endcase
                        r_idx <= r_idx + CW'(1);
                        if (r_idx == r_total - CW'(1)) begin
                            if (r_cmd == CMD_POP) begin
                                r_cnt <= r_cnt - r_total;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_SLOAD: begin
                    // One read per cycle; the data is inserted in the next cycle.
                    r_ins <= hit;
                    if (hit) begin
                        r_idx <= r_idx + CW'(1);
                    end else if (!r_ins) begin
                        r_idx   <= '0;
                        r_state <= S_SEMIT;
                    end
                end
                S_SEMIT: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_status  <= ST_OK;
                        r_value   <= sort_top;
                        r_pos     <= r_idx;
                        r_occ     <= r_cnt;
                        r_last    <= (r_idx == CW'(DEPTH - 1));
                        r_idx     <= r_idx + CW'(1);
                        if (r_idx == CW'(DEPTH - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Ports.
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {{(OUT_W - VAL_W - 2 * CW){1'b0}}, r_occ, r_pos, r_value};

`ifndef SYNTHESIS
    // An accepted command keeps the sequencer busy in the cycle after acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("sequencer accepted two commands back to back");

    // The stack count changes only when a push or the last pop result commits.
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state == S_DECODE) || (r_state == S_DATA)) |=> $stable(r_cnt))
        else $error("stack count changed outside a commit");

    // The occupancy never exceeds the depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CW'(DEPTH)))
        else $error("stack count beyond depth");

    // A pending result stays until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("pending result dropped");
`endif

endmodule
`default_nettype wire
